/* rtl/bilinear_hysteretic_material_step_defines.svh */
// Assertion macros shared by the material step RTL.
`ifndef BILINEAR_HYSTERETIC_MATERIAL_STEP_DEFINES_SVH
`define BILINEAR_HYSTERETIC_MATERIAL_STEP_DEFINES_SVH

// Check an implication in the same cycle, masked while in reset.
`define BHMS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, masked while in reset.
`define BHMS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bhms_pkg.sv */
// Types, constants and microprogram of the bilinear hysteretic material step.
`default_nettype none

package bhms_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned FuncW      = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned HardW      = 16;
  localparam int unsigned StepW      = 5;
  localparam int unsigned HardFrac   = 16;
  localparam int unsigned StrainFrac = 29;
  localparam int unsigned ComplFrac  = 32;

  localparam logic [WordW-1:0] ModulusRst    = 32'd819200000;
  localparam logic [WordW-1:0] ComplianceRst = 32'd2814749767;

  localparam logic [StepW-1:0] StepTension     = StepW'(8);
  localparam logic [StepW-1:0] StepCompression = StepW'(17);

  typedef enum logic [FuncW-1:0] {
    FUNC_TRIAL   = 2'd0,
    FUNC_COMMIT  = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_REVERT  = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODULUS     = 3'd0,
    CFG_COMPLIANCE  = 3'd1,
    CFG_TY_INIT     = 3'd2,
    CFG_CY_INIT     = 3'd3,
    CFG_TENSION_H   = 3'd4,
    CFG_COMPRESS_H  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } bhms_state_e;

  typedef enum logic [2:0] {
    MA_FT,
    MA_FN,
    MA_MOD,
    MA_T2,
    MA_TTY,
    MA_TCY
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_COMP,
    MB_MOD,
    MB_TH,
    MB_CH,
    MB_TAN
  } mul_b_e;

  typedef enum logic [1:0] {
    SH_16,
    SH_29,
    SH_32
  } shift_e;

  typedef enum logic [1:0] {
    ALU_NOP,
    ALU_ADD,
    ALU_SUB,
    ALU_RND
  } alu_op_e;

  typedef enum logic [3:0] {
    SRC_E,
    SRC_EP,
    SRC_FT,
    SRC_FN,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_TTY,
    SRC_TCY
  } alu_src_e;

  typedef enum logic [3:0] {
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3,
    DST_TAN,
    DST_TEP,
    DST_TTY,
    DST_TCY,
    DST_SIG,
    DST_SIG_TTY,
    DST_SIG_TCY
  } alu_dst_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_GT,
    JMP_LT
  } jump_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [WordW-1:0] strain_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [WordW-1:0] strain_out;
    logic signed [WordW-1:0] stress_out;
    logic [WordW-1:0]        tangent_out;
  } out_beat_t;

  typedef struct packed {
    logic [WordW-1:0]        modulus;
    logic [WordW-1:0]        compliance;
    logic [WordW-2:0]        ty_init;
    logic signed [WordW-1:0] cy_init;
    logic [HardW-1:0]        th;
    logic [HardW-1:0]        ch;
  } cfg_t;

  typedef struct packed {
    logic load_e;
    logic commit;
    logic restart;
    logic revert;
  } cmd_t;

  typedef struct packed {
    logic same;
    logic gt;
    logic lt;
  } flags_t;

  typedef struct packed {
    logic             mul_en;
    mul_a_e           mul_a;
    mul_b_e           mul_b;
    shift_e           mul_sh;
    alu_op_e          alu_op;
    alu_src_e         alu_a;
    alu_src_e         alu_b;
    alu_dst_e         alu_dst;
    logic             tan_mod;
    logic             keep_yield;
    jump_e            jump;
    logic [StepW-1:0] target;
    logic             last;
  } ucode_t;

  localparam ucode_t UcodeNop = '0;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = UcodeNop;
    unique case (step)
      StepW'(0): begin
        w.mul_en = 1'b1; w.mul_a = MA_FT; w.mul_b = MB_COMP; w.mul_sh = SH_32;
      end
      StepW'(1): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_T0;
        w.mul_en = 1'b1; w.mul_a = MA_FN; w.mul_b = MB_COMP; w.mul_sh = SH_32;
      end
      StepW'(2): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_T1;
      end
      StepW'(3): begin
        w.alu_op = ALU_ADD; w.alu_a = SRC_EP; w.alu_b = SRC_T0; w.alu_dst = DST_T0;
      end
      StepW'(4): begin
        w.alu_op = ALU_ADD; w.alu_a = SRC_EP; w.alu_b = SRC_T1; w.alu_dst = DST_T1;
      end
      StepW'(5): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_E; w.alu_b = SRC_EP; w.alu_dst = DST_T2;
        w.jump = JMP_GT; w.target = StepTension;
      end
      StepW'(6): begin
        w.mul_en = 1'b1; w.mul_a = MA_T2; w.mul_b = MB_MOD; w.mul_sh = SH_29;
        w.jump = JMP_LT; w.target = StepCompression;
      end
      StepW'(7): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_SIG;
        w.tan_mod = 1'b1; w.keep_yield = 1'b1; w.last = 1'b1;
      end
      StepW'(8): begin
        w.mul_en = 1'b1; w.mul_a = MA_MOD; w.mul_b = MB_TH; w.mul_sh = SH_16;
        w.alu_op = ALU_SUB; w.alu_a = SRC_E; w.alu_b = SRC_T0; w.alu_dst = DST_T2;
      end
      StepW'(9): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_TAN;
      end
      StepW'(10): begin
        w.mul_en = 1'b1; w.mul_a = MA_T2; w.mul_b = MB_TAN; w.mul_sh = SH_29;
      end
      StepW'(11): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_T3;
      end
      StepW'(12): begin
        w.alu_op = ALU_ADD; w.alu_a = SRC_T3; w.alu_b = SRC_FT; w.alu_dst = DST_SIG_TTY;
      end
      StepW'(13): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_FT; w.alu_b = SRC_FN; w.alu_dst = DST_T2;
        w.mul_en = 1'b1; w.mul_a = MA_TTY; w.mul_b = MB_COMP; w.mul_sh = SH_32;
      end
      StepW'(14): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_T3;
      end
      StepW'(15): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_TTY; w.alu_b = SRC_T2; w.alu_dst = DST_TCY;
      end
      StepW'(16): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_E; w.alu_b = SRC_T3; w.alu_dst = DST_TEP;
        w.last = 1'b1;
      end
      StepW'(17): begin
        w.mul_en = 1'b1; w.mul_a = MA_MOD; w.mul_b = MB_CH; w.mul_sh = SH_16;
        w.alu_op = ALU_SUB; w.alu_a = SRC_E; w.alu_b = SRC_T1; w.alu_dst = DST_T2;
      end
      StepW'(18): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_TAN;
      end
      StepW'(19): begin
        w.mul_en = 1'b1; w.mul_a = MA_T2; w.mul_b = MB_TAN; w.mul_sh = SH_29;
      end
      StepW'(20): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_T3;
      end
      StepW'(21): begin
        w.alu_op = ALU_ADD; w.alu_a = SRC_T3; w.alu_b = SRC_FN; w.alu_dst = DST_SIG_TCY;
      end
      StepW'(22): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_FN; w.alu_b = SRC_FT; w.alu_dst = DST_T2;
        w.mul_en = 1'b1; w.mul_a = MA_TCY; w.mul_b = MB_COMP; w.mul_sh = SH_32;
      end
      StepW'(23): begin
        w.alu_op = ALU_RND; w.alu_dst = DST_T3;
      end
      StepW'(24): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_TCY; w.alu_b = SRC_T2; w.alu_dst = DST_TTY;
      end
      StepW'(25): begin
        w.alu_op = ALU_SUB; w.alu_a = SRC_E; w.alu_b = SRC_T3; w.alu_dst = DST_TEP;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/bhms_seq.sv */
// Microprogram sequencer: step counter, control store and conditional jumps.
`default_nettype none

module bhms_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bhms_pkg::flags_t flags_i,
  output bhms_pkg::ucode_t ctrl_o,
  output logic             busy_o,
  output logic             done_o
);
  import bhms_pkg::*;

  logic             run_q, run_d;
  logic [StepW-1:0] step_q, step_d;
  ucode_t           word;
  logic             take;

  always_comb begin
    word   = ucode_rom(step_q);
    take   = (word.jump == JMP_GT && flags_i.gt) || (word.jump == JMP_LT && flags_i.lt);
    ctrl_o = run_q ? word : UcodeNop;
    done_o = run_q && word.last;
    busy_o = run_q;
    run_d  = run_q;
    step_d = step_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
    end else if (run_q) begin
      if (word.last) begin
        run_d = 1'b0;
      end else if (take) begin
        step_d = word.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/bhms_dp.sv */
// Datapath: material state, shared multiplier with rounding, saturating adder.
`default_nettype none

module bhms_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bhms_pkg::cfg_t          cfg_i,
  input  bhms_pkg::cmd_t          cmd_i,
  input  bhms_pkg::ucode_t        ctrl_i,
  input  logic signed [31:0]      strain_i,
  output bhms_pkg::flags_t        flags_o,
  output bhms_pkg::out_beat_t     trial_o
);
  import bhms_pkg::*;

  localparam int unsigned PW = 2 * WordW + 1;

  logic signed [WordW-1:0] c_strain_q, c_stress_q, c_ep_q, c_ty_q, c_cy_q;
  logic [WordW-1:0]        c_tan_q;
  logic signed [WordW-1:0] t_strain_q, t_stress_q, t_ep_q, t_ty_q, t_cy_q;
  logic [WordW-1:0]        t_tan_q;

  logic signed [WordW-1:0] e_q, t0_q, t1_q, t2_q, t3_q;
  logic [PW-1:0]           prod_q, prod_d;
  logic                    neg_q;
  shift_e                  sh_q;

  logic signed [WordW:0]   mul_a;
  logic [WordW:0]          mag;
  logic [WordW-1:0]        mul_b;
  logic [PW:0]             rsum, rq, lim, sat;
  logic signed [WordW-1:0] rnd_res, alu_a, alu_b, alu_res;

  function automatic logic signed [WordW-1:0] sat_add(input logic signed [WordW-1:0] a,
                                                      input logic signed [WordW-1:0] b,
                                                      input logic sub);
    logic signed [WordW:0] s;
    s = sub ? ((WordW+1)'(a) - (WordW+1)'(b)) : ((WordW+1)'(a) + (WordW+1)'(b));
    if (s[WordW] != s[WordW-1]) begin
      sat_add = s[WordW] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
    end else begin
      sat_add = s[WordW-1:0];
    end
  endfunction

  always_comb begin
    case (ctrl_i.mul_a)
      MA_FT:   mul_a = (WordW+1)'(c_ty_q);
      MA_FN:   mul_a = (WordW+1)'(c_cy_q);
      MA_MOD:  mul_a = signed'({1'b0, cfg_i.modulus});
      MA_T2:   mul_a = (WordW+1)'(t2_q);
      MA_TTY:  mul_a = (WordW+1)'(t_ty_q);
      MA_TCY:  mul_a = (WordW+1)'(t_cy_q);
      default: mul_a = '0;
    endcase
    case (ctrl_i.mul_b)
      MB_COMP: mul_b = cfg_i.compliance;
      MB_MOD:  mul_b = cfg_i.modulus;
      MB_TH:   mul_b = WordW'(cfg_i.th);
      MB_CH:   mul_b = WordW'(cfg_i.ch);
      MB_TAN:  mul_b = t_tan_q;
      default: mul_b = '0;
    endcase
    mag    = mul_a[WordW] ? (WordW+1)'(-mul_a) : (WordW+1)'(mul_a);
    prod_d = PW'(mag) * PW'(mul_b);
  end

  always_comb begin
    case (sh_q)
      SH_16: begin
        rsum = {1'b0, prod_q} + ((PW+1)'(1) << (HardFrac - 1));
        rq   = rsum >> HardFrac;
      end
      SH_29: begin
        rsum = {1'b0, prod_q} + ((PW+1)'(1) << (StrainFrac - 1));
        rq   = rsum >> StrainFrac;
      end
      SH_32: begin
        rsum = {1'b0, prod_q} + ((PW+1)'(1) << (ComplFrac - 1));
        rq   = rsum >> ComplFrac;
      end
      default: begin
        rsum = {1'b0, prod_q};
        rq   = rsum;
      end
    endcase
    lim = neg_q ? ((PW+1)'(1) << (WordW - 1))
                : (((PW+1)'(1) << (WordW - 1)) - (PW+1)'(1));
    sat = (rq > lim) ? lim : rq;
    rnd_res = neg_q ? -$signed(sat[WordW-1:0]) : $signed(sat[WordW-1:0]);
  end

  always_comb begin
    case (ctrl_i.alu_a)
      SRC_E:   alu_a = e_q;
      SRC_EP:  alu_a = c_ep_q;
      SRC_FT:  alu_a = c_ty_q;
      SRC_FN:  alu_a = c_cy_q;
      SRC_T0:  alu_a = t0_q;
      SRC_T1:  alu_a = t1_q;
      SRC_T2:  alu_a = t2_q;
      SRC_T3:  alu_a = t3_q;
      SRC_TTY: alu_a = t_ty_q;
      SRC_TCY: alu_a = t_cy_q;
      default: alu_a = '0;
    endcase
    case (ctrl_i.alu_b)
      SRC_E:   alu_b = e_q;
      SRC_EP:  alu_b = c_ep_q;
      SRC_FT:  alu_b = c_ty_q;
      SRC_FN:  alu_b = c_cy_q;
      SRC_T0:  alu_b = t0_q;
      SRC_T1:  alu_b = t1_q;
      SRC_T2:  alu_b = t2_q;
      SRC_T3:  alu_b = t3_q;
      SRC_TTY: alu_b = t_ty_q;
      SRC_TCY: alu_b = t_cy_q;
      default: alu_b = '0;
    endcase
    case (ctrl_i.alu_op)
      ALU_ADD: alu_res = sat_add(alu_a, alu_b, 1'b0);
      ALU_SUB: alu_res = sat_add(alu_a, alu_b, 1'b1);
      ALU_RND: alu_res = rnd_res;
      default: alu_res = '0;
    endcase
  end

  assign flags_o.same = (strain_i == c_strain_q);
  assign flags_o.gt   = (e_q > t0_q);
  assign flags_o.lt   = (e_q < t1_q);

  assign trial_o.strain_out  = t_strain_q;
  assign trial_o.stress_out  = t_stress_q;
  assign trial_o.tangent_out = t_tan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_e) begin
      e_q <= strain_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      neg_q  <= mul_a[WordW];
      sh_q   <= ctrl_i.mul_sh;
    end
    if (ctrl_i.alu_op != ALU_NOP) begin
      case (ctrl_i.alu_dst)
        DST_T0:  t0_q <= alu_res;
        DST_T1:  t1_q <= alu_res;
        DST_T2:  t2_q <= alu_res;
        DST_T3:  t3_q <= alu_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_strain_q <= '0;
      c_stress_q <= '0;
      c_tan_q    <= ModulusRst;
      c_ep_q     <= '0;
      c_ty_q     <= '0;
      c_cy_q     <= '0;
      t_strain_q <= '0;
      t_stress_q <= '0;
      t_tan_q    <= ModulusRst;
      t_ep_q     <= '0;
      t_ty_q     <= '0;
      t_cy_q     <= '0;
    end else if (cmd_i.restart) begin
      c_strain_q <= '0;
      c_stress_q <= '0;
      c_tan_q    <= cfg_i.modulus;
      c_ep_q     <= '0;
      c_ty_q     <= signed'({1'b0, cfg_i.ty_init});
      c_cy_q     <= cfg_i.cy_init;
      t_strain_q <= '0;
      t_stress_q <= '0;
      t_tan_q    <= cfg_i.modulus;
      t_ep_q     <= '0;
      t_ty_q     <= signed'({1'b0, cfg_i.ty_init});
      t_cy_q     <= cfg_i.cy_init;
    end else if (cmd_i.commit) begin
      c_strain_q <= t_strain_q;
      c_stress_q <= t_stress_q;
      c_tan_q    <= t_tan_q;
      c_ep_q     <= t_ep_q;
      c_ty_q     <= t_ty_q;
      c_cy_q     <= t_cy_q;
    end else if (cmd_i.revert) begin
      t_strain_q <= c_strain_q;
      t_stress_q <= c_stress_q;
      t_tan_q    <= c_tan_q;
      t_ep_q     <= c_ep_q;
      t_ty_q     <= c_ty_q;
      t_cy_q     <= c_cy_q;
    end else begin
      if (ctrl_i.last) begin
        t_strain_q <= e_q;
      end
      if (ctrl_i.tan_mod) begin
        t_tan_q <= cfg_i.modulus;
      end
      if (ctrl_i.keep_yield) begin
        t_ep_q <= c_ep_q;
        t_ty_q <= c_ty_q;
        t_cy_q <= c_cy_q;
      end
      if (ctrl_i.alu_op != ALU_NOP) begin
        case (ctrl_i.alu_dst)
          DST_TAN:  t_tan_q <= unsigned'(alu_res);
          DST_TEP:  t_ep_q  <= alu_res;
          DST_TTY:  t_ty_q  <= alu_res;
          DST_TCY:  t_cy_q  <= alu_res;
          DST_SIG:  t_stress_q <= alu_res;
          DST_SIG_TTY: begin
            t_stress_q <= alu_res;
            t_ty_q     <= alu_res;
          end
          DST_SIG_TCY: begin
            t_stress_q <= alu_res;
            t_cy_q     <= alu_res;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/bilinear_hysteretic_material_step.sv */
// Top level of the bilinear hysteretic material step.
//
// One input beat carries a function code and a trial strain; every beat returns one
// output beat with the trial strain, stress and tangent after the update.
// Commit, revert to start, revert to last commit and a trial at the committed strain
// take effect at acceptance; their result is loaded afterwards, from the finish state.
// A trial strain runs a microprogram on one shared multiplier and one saturating
// adder: 8 steps when elastic, 15 when yielding in tension, 16 in compression. The
// result is loaded after the last step, from the finish state once the output register
// is free; a new beat is taken only after that load, with the block back in idle.
// The output register holds a finished beat while the next item is already running;
// if the receiver still stalls when that item finishes, the block waits with it.
// Configuration writes are always ready; modulus, compliance and hardening apply from
// the next trial, the initial yields only from the next restart. Write them only while
// no item is pending.
// Reset loads the register defaults and the initial material state, clears the
// output valid and returns the sequencer to idle.
`default_nettype none
`include "bilinear_hysteretic_material_step_defines.svh"

module bilinear_hysteretic_material_step (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  bhms_pkg::in_beat_t      in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bhms_pkg::out_beat_t     out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i
);
  import bhms_pkg::*;

  bhms_state_e state_q, state_d;
  cfg_t        cfg_q;
  cmd_t        cmd;
  flags_t      flags;
  ucode_t      ctrl;
  out_beat_t   trial;
  out_beat_t   out_data_q;
  logic        out_valid_q;
  logic        accept, out_load, seq_start, seq_busy, seq_done;
  logic        same_trial;

  assign accept      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign same_trial  = accept && in_data_i.func == FUNC_TRIAL && flags.same;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.func == FUNC_TRIAL && !flags.same) ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        if (seq_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    seq_start  = 1'b0;
    cmd        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          unique case (func_e'(in_data_i.func))
            FUNC_TRIAL: begin
              cmd.load_e = 1'b1;
              seq_start  = !flags.same;
            end
            FUNC_COMMIT:  cmd.commit  = 1'b1;
            FUNC_RESTART: cmd.restart = 1'b1;
            FUNC_REVERT:  cmd.revert  = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: ;
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus    <= ModulusRst;
      cfg_q.compliance <= ComplianceRst;
      cfg_q.ty_init    <= '0;
      cfg_q.cy_init    <= '0;
      cfg_q.th         <= '0;
      cfg_q.ch         <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODULUS:    cfg_q.modulus    <= cfg_data_i;
        CFG_COMPLIANCE: cfg_q.compliance <= cfg_data_i;
        CFG_TY_INIT:    cfg_q.ty_init    <= cfg_data_i[WordW-2:0];
        CFG_CY_INIT:    cfg_q.cy_init    <= signed'(cfg_data_i);
        CFG_TENSION_H:  cfg_q.th         <= cfg_data_i[HardW-1:0];
        CFG_COMPRESS_H: cfg_q.ch         <= cfg_data_i[HardW-1:0];
        default: ;
      endcase
    end
  end

  bhms_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seq_start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (seq_busy),
    .done_o  (seq_done)
  );

  bhms_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .ctrl_i   (ctrl),
    .strain_i (in_data_i.strain_in),
    .flags_o  (flags),
    .trial_o  (trial)
  );

  `BHMS_ASSERT_IMP(a_done_in_run, seq_done, state_q == ST_RUN, "sequencer done outside run")
  `BHMS_ASSERT_IMP(a_run_busy, state_q == ST_RUN, seq_busy, "run state with idle sequencer")
  `BHMS_ASSERT_IMP(a_idle_quiet, state_q != ST_RUN, !seq_busy, "sequencer busy outside run")
  `BHMS_ASSERT_IMP(a_load_after_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "stray load")
  `BHMS_ASSERT_NXT(a_same_skips_run, same_trial, state_q == ST_FIN, "unchanged strain ran")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking bench for the bilinear hysteretic material step: directed and random beats.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bhms_pkg::*;

  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;
  localparam logic [CfgIdxW-1:0] CfgSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = 3'd7;
  localparam int SettleCycles = 24;
  localparam int RandomPerMode = 50;

  typedef struct {
    longint      strain;
    longint      stress;
    longint      plastic;
    longint      ty;
    longint      cy;
    logic [31:0] tangent;
  } material_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] mod_reg, comp_reg;
  longint ty_init_reg, cy_init_reg;
  logic [15:0] th_reg, ch_reg;
  material_t committed, trial;

  out_beat_t awaited[$];
  out_beat_t want;
  int mismatches = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int regs_written = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_cycles = 0;

  bilinear_hysteretic_material_step uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_word(longint v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  // round(a * b / 2^sh) half away from zero, saturated to a word
  function automatic longint scale_round(longint a, logic [31:0] b, int sh);
    logic [95:0] prod;
    logic [95:0] lim;
    logic [63:0] mag;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    prod = (96'(mag) * 96'(b) + (96'd1 << (sh - 1))) >> sh;
    lim = (a < 0) ? 96'h8000_0000 : 96'h7FFF_FFFF;
    if (prod > lim) prod = lim;
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint yield_strain(bit tension);
    return clamp_word(committed.plastic +
                      scale_round(tension ? committed.ty : committed.cy, comp_reg, 32));
  endfunction

  function automatic void restart_material();
    committed.strain = 0;
    committed.stress = 0;
    committed.plastic = 0;
    committed.tangent = mod_reg;
    committed.ty = ty_init_reg;
    committed.cy = cy_init_reg;
    trial = committed;
  endfunction

  function automatic void run_trial(longint e);
    longint ep, ft, fn, eyt, eyn, sig, nt, nn, nep;
    logic [31:0] tan;
    ep = committed.plastic;
    ft = committed.ty;
    fn = committed.cy;
    eyt = yield_strain(1'b1);
    eyn = yield_strain(1'b0);
    if (e > eyt) begin
      tan = 32'(scale_round(longint'(mod_reg), {16'd0, th_reg}, 16));
      sig = clamp_word(scale_round(clamp_word(e - eyt), tan, 29) + ft);
      nt = sig;
      nn = clamp_word(nt - clamp_word(ft - fn));
      nep = clamp_word(e - scale_round(nt, comp_reg, 32));
    end else if (e < eyn) begin
      tan = 32'(scale_round(longint'(mod_reg), {16'd0, ch_reg}, 16));
      sig = clamp_word(scale_round(clamp_word(e - eyn), tan, 29) + fn);
      nn = sig;
      nt = clamp_word(nn - clamp_word(fn - ft));
      nep = clamp_word(e - scale_round(nn, comp_reg, 32));
    end else begin
      tan = mod_reg;
      sig = scale_round(clamp_word(e - ep), mod_reg, 29);
      nt = ft;
      nn = fn;
      nep = ep;
    end
    trial.strain = e;
    trial.stress = sig;
    trial.tangent = tan;
    trial.plastic = nep;
    trial.ty = nt;
    trial.cy = nn;
  endfunction

  function automatic out_beat_t material_step(func_e f, logic signed [31:0] e_in);
    longint e;
    out_beat_t r;
    e = longint'(e_in);
    case (f)
      FUNC_TRIAL:   if (e != committed.strain) run_trial(e);
      FUNC_COMMIT:  committed = trial;
      FUNC_RESTART: restart_material();
      FUNC_REVERT:  trial = committed;
      default:      ;
    endcase
    r.strain_out = trial.strain[31:0];
    r.stress_out = trial.stress[31:0];
    r.tangent_out = trial.tangent;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    case (idx)
      CFG_MODULUS:    mod_reg = v;
      CFG_COMPLIANCE: comp_reg = v;
      CFG_TY_INIT:    ty_init_reg = longint'({1'b0, v[30:0]});
      CFG_CY_INIT:    cy_init_reg = longint'(signed'(v));
      CFG_TENSION_H:  th_reg = v[15:0];
      CFG_COMPRESS_H: ch_reg = v[15:0];
      default:        ;
    endcase
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (recv_hold_cycles > 0) begin
        out_ready <= 1'b0;
        recv_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: strain %0d stress %0d tangent %0d",
               out_data.strain_out, out_data.stress_out, out_data.tangent_out);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        results_checked++;
        if (out_data.strain_out !== want.strain_out) begin
          $error("strain_out: expected %0d, got %0d", want.strain_out, out_data.strain_out);
          mismatches++;
        end
        if (out_data.stress_out !== want.stress_out) begin
          $error("stress_out: expected %0d, got %0d", want.stress_out, out_data.stress_out);
          mismatches++;
        end
        if (out_data.tangent_out !== want.tangent_out) begin
          $error("tangent_out: expected %0d, got %0d", want.tangent_out,
                 out_data.tangent_out);
          mismatches++;
        end
      end
    end
  end

  task automatic send_beat(func_e f, logic signed [31:0] e);
    in_beat_t b;
    b.func = f;
    b.strain_in = e;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited.push_back(material_step(f, e));
    beats_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
    regs_written++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(logic [31:0] md, logic [31:0] cp, logic [31:0] ty,
                              logic [31:0] cy, logic [31:0] th, logic [31:0] ch);
    wait_idle();
    write_reg(CFG_MODULUS, md);
    write_reg(CFG_COMPLIANCE, cp);
    write_reg(CFG_TY_INIT, ty);
    write_reg(CFG_CY_INIT, cy);
    write_reg(CFG_TENSION_H, th);
    write_reg(CFG_COMPRESS_H, ch);
    send_beat(FUNC_RESTART, $urandom);
  endtask

  task automatic load_nominal();
    load_setting(32'd819200000, 32'd2814749767, 32'd1024000, -32'sd1024000,
                 32'd1311, 32'd3277);
  endtask

  task automatic send_random_beat();
    int pick;
    int span;
    longint near;
    logic signed [31:0] e;
    pick = $urandom_range(0, 99);
    span = $urandom_range(1, 1 << 22);
    e = $urandom;
    if (pick < 55) begin
      near = clamp_word(committed.strain + longint'($urandom_range(0, 2 * span)) -
                        longint'(span));
      send_beat(FUNC_TRIAL, near[31:0]);
    end else if (pick < 63) begin
      send_beat(FUNC_TRIAL, e);
    end else if (pick < 68) begin
      send_beat(FUNC_TRIAL, committed.strain[31:0]);
    end else if (pick < 70) begin
      send_beat(FUNC_TRIAL, pick[0] ? WordMax[31:0] : WordMin[31:0]);
    end else if (pick < 86) begin
      send_beat(FUNC_COMMIT, e);
    end else if (pick < 94) begin
      send_beat(FUNC_REVERT, e);
    end else begin
      send_beat(FUNC_RESTART, e);
    end
  endtask

  task automatic do_reset();
    mod_reg = ModulusRst;
    comp_reg = ComplianceRst;
    ty_init_reg = 0;
    cy_init_reg = 0;
    th_reg = '0;
    ch_reg = '0;
    restart_material();
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_beat(FUNC_TRIAL, 32'sd0);
    send_beat(FUNC_TRIAL, WordMax[31:0]);
    send_beat(FUNC_TRIAL, WordMin[31:0]);
    send_beat(FUNC_COMMIT, 32'sd0);
    send_beat(FUNC_REVERT, 32'sd0);
    send_beat(FUNC_RESTART, 32'sd0);
  endtask

  task automatic test_yield_edges();
    longint yt, yn;
    load_nominal();
    yt = yield_strain(1'b1);
    send_beat(FUNC_TRIAL, 32'(yt / 2));
    send_beat(FUNC_TRIAL, 32'(yt));
    send_beat(FUNC_TRIAL, 32'(yt + 1));
    send_beat(FUNC_TRIAL, 32'(yt + 300000));
    send_beat(FUNC_COMMIT, 32'sd0);
    send_beat(FUNC_TRIAL, committed.strain[31:0]);
    yn = yield_strain(1'b0);
    send_beat(FUNC_TRIAL, 32'(yn));
    send_beat(FUNC_TRIAL, 32'(yn - 1));
    send_beat(FUNC_TRIAL, 32'(yn - 400000));
    send_beat(FUNC_REVERT, 32'sd0);
    send_beat(FUNC_TRIAL, 32'(yn - 400000));
    send_beat(FUNC_COMMIT, 32'sd0);
    send_beat(FUNC_RESTART, 32'sd0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_cycles = 400;
    repeat (16) send_random_beat();
    wait_idle();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 26;
    recv_stall_pct = 26;
    repeat (20) send_random_beat();
    wait_idle();
    repeat (20) send_random_beat();
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: load_nominal();
        1: load_setting(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: load_setting(32'h0, 32'hFFFF_FFFF, 32'h0, 32'd5000, 32'h0, 32'h0);
        default: begin
          wait_idle();
          write_reg(CfgSpare6, $urandom);
          write_reg(CfgSpare7, $urandom);
          load_setting($urandom, $urandom, $urandom, $urandom | 32'h8000_0000,
                       $urandom, $urandom);
        end
      endcase
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
          default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
        repeat (RandomPerMode) send_random_beat();
      end
    end
  endtask

  initial begin
    do_reset();
    test_reset_state();
    test_yield_edges();
    test_backpressure();
    test_sender_pause();
    test_random_settings();
    wait_idle();
    repeat (SettleCycles) @(posedge clk);
    $display("summary: %0d beats (trial, commit, both reverts) over 5 register settings,",
             beats_sent);
    $display("summary: %0d results checked, %0d register writes, %0d mismatches",
             results_checked, regs_written, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still awaited", awaited.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/bhms_pkg.sv
rtl/bhms_seq.sv
rtl/bhms_dp.sv
rtl/bilinear_hysteretic_material_step.sv
sim/testbench.sv
